[rtl/assert_macros.svh]
// Assertion macros shared by the character LCD queue RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define CLCD_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the cycle after.
`define CLCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/clcd_pkg.sv]
// Shared types and constants for the character LCD write queue.
// No dependencies; used by the controller, the datapath and the top level.
package clcd_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int NUM_BUFS        = 4;

    localparam int TICK_W  = 10;
    localparam int WAIT_W  = 16;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 2;
    localparam int ENTRY_W = 12;

    localparam logic [INDEX_W-1:0] REG_TICK_PERIOD = 2'd0;
    localparam logic [INDEX_W-1:0] REG_INSTR_WAIT  = 2'd1;

    localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 10'd1;
    localparam logic [WAIT_W-1:0] INSTR_WAIT_RST  = 16'd50;

    localparam logic [7:0] LCD_SET_ADDR = 8'h80;
    localparam logic [7:0] LCD_LINE2    = 8'h40;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_out;
        logic push;
        logic wait_sub;
        logic load_instr;
        logic load_period;
        logic emit_instr;
        logic emit_data;
        logic pop;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic wait_zero;
        logic any_ready;
    } sts_t;

endpackage

[rtl/char_lcd_update_queue_top.sv]
// Top level of the character LCD write queue.
// Depends on clcd_pkg, clcd_ctrl and clcd_dp.
//
//   Channel   Direction   Handshake            Payload
//   in        request in  in_tvalid/in_tready  in_tuser, in_tdata
//   out       result out  out_tvalid/out_tready out_tdata
//   cfg       write in    cfg_we               cfg_index, cfg_data
//
// Each request's result is loaded into the output register at the edge that
// accepts it, and a pop reads the character store at that edge.
// A new request is taken whenever the output register is empty or being drained,
// so the output stall alone holds off the input.
// Reset is asynchronous and active low; the character store is not cleared.
module char_lcd_update_queue_top
    import clcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_tvalid,
    output logic               in_tready,
    input  logic [15:0]        in_tdata,   // char_code[7:0], position[11:8], zeros
    input  logic               in_tuser,   // op: 0 push, 1 tick
    output logic               out_tvalid,
    input  logic               out_tready,
    output logic [15:0]        out_tdata,  // write_valid[0], write_is_data[1],
                                           // write_byte[9:2], push_ok[10],
                                           // overflow[11], zeros
    input  logic               cfg_we,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    cmd_t cmd;
    sts_t sts;

    clcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (in_tvalid),
        .op        (in_tuser),
        .sts       (sts),
        .in_tready (in_tready),
        .cmd       (cmd)
    );

    clcd_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .char_code  (in_tdata[7:0]),
        .position   (in_tdata[11:8]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_tready (out_tready),
        .sts        (sts),
        .out_tvalid (out_tvalid),
        .out_tdata  (out_tdata)
    );

endmodule

[rtl/clcd_ctrl.sv]
// Controller of the character LCD write queue: handshake and phase machine.
// Depends on clcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clcd_ctrl
    import clcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_tvalid,
    input  logic op,
    input  sts_t sts,
    output logic in_tready,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MOVE,
        PH_DISPLAY
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;
    logic   accept;

    assign in_tready = sts.out_free;
    assign accept    = in_tvalid && in_tready;

    always_comb
    begin
        cmd        = '0;
        phase_next = phase_reg;
        if (accept)
        begin
            cmd.load_out = 1'b1;
            if (!op)
            begin
                cmd.push = 1'b1;
            end
            else if (!sts.wait_zero)
            begin
                cmd.wait_sub = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_MOVE:
                    begin
                        cmd.emit_instr = 1'b1;
                        cmd.load_instr = 1'b1;
                        phase_next     = PH_DISPLAY;
                    end
                    PH_DISPLAY:
                    begin
                        cmd.emit_data   = 1'b1;
                        cmd.load_period = 1'b1;
                        cmd.pop         = sts.any_ready;
                        phase_next      = sts.any_ready ? PH_MOVE : PH_IDLE;
                    end
                    default:
                    begin
                        // The decremented wait is already zero here, so the wait is cleared.
                        cmd.wait_sub = 1'b1;
                        cmd.pop      = sts.any_ready;
                        phase_next   = sts.any_ready ? PH_MOVE : PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    `CLCD_ASSERT_NEXT(a_instr_then_display, cmd.emit_instr, phase_reg == PH_DISPLAY,
        "set-address write not followed by the display phase")
    `CLCD_ASSERT_NEXT(a_pop_then_move, cmd.pop, phase_reg == PH_MOVE,
        "pop not followed by the move phase")
    `CLCD_ASSERT(a_push_alone, !cmd.push || (!cmd.pop && !cmd.emit_data && !cmd.emit_instr),
        "push request mixed with LCD activity")

endmodule

[rtl/clcd_dp.sv]
// Datapath of the character LCD write queue: ring buffers, wait counter,
// target entry and result register. Depends on clcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clcd_dp
    import clcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [7:0]         char_code,
    input  logic [3:0]         position,
    input  logic               cfg_we,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               out_tready,
    output sts_t               sts,
    output logic               out_tvalid,
    output logic [15:0]        out_tdata
);

    localparam int SW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int PW        = SW + 1;
    localparam int SPAN      = 2 * QUEUE_DEPTH;
    localparam int MEM_DEPTH = NUM_BUFS * (2 ** SW);
    localparam int AW        = SW + 2;

    logic [ENTRY_W-1:0] mem [MEM_DEPTH];

    logic [PW-1:0]      wp_reg [NUM_BUFS];
    logic [PW-1:0]      rp_reg [NUM_BUFS];
    logic [WAIT_W-1:0]  wait_reg;
    logic [TICK_W-1:0]  tick_period_reg;
    logic [WAIT_W-1:0]  instr_wait_reg;
    logic [ENTRY_W-1:0] target_reg;
    logic               out_valid_reg;
    logic [11:0]        out_data_reg;

    logic [SW-1:0]      wslot [NUM_BUFS];
    logic [SW-1:0]      rslot [NUM_BUFS];
    logic [PW-1:0]      wbump [NUM_BUFS];
    logic [PW-1:0]      rbump [NUM_BUFS];
    logic [PW:0]        fill [NUM_BUFS];
    logic [PW:0]        diff [NUM_BUFS];
    logic [NUM_BUFS-1:0] full;
    logic [NUM_BUFS-1:0] ready;
    logic [1:0]         push_buf;
    logic [1:0]         pop_buf;
    logic               push_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [WAIT_W-1:0]  tick_ext;
    logic [WAIT_W-1:0]  wait_dec;
    logic [7:0]         addr_byte;
    logic [7:0]         out_byte;
    logic [3:0]         target_pos;

    // Ring pointers count modulo twice the depth so full and empty differ.
    always_comb
    begin
        for (int b = 0; b < NUM_BUFS; b++)
        begin
            wslot[b] = (wp_reg[b] >= PW'(QUEUE_DEPTH)) ?
                       SW'(wp_reg[b] - PW'(QUEUE_DEPTH)) : SW'(wp_reg[b]);
            rslot[b] = (rp_reg[b] >= PW'(QUEUE_DEPTH)) ?
                       SW'(rp_reg[b] - PW'(QUEUE_DEPTH)) : SW'(rp_reg[b]);
            wbump[b] = (wp_reg[b] == PW'(SPAN - 1)) ? '0 : wp_reg[b] + 1'b1;
            rbump[b] = (rp_reg[b] == PW'(SPAN - 1)) ? '0 : rp_reg[b] + 1'b1;
            diff[b]  = {1'b0, wp_reg[b]} - {1'b0, rp_reg[b]};
            fill[b]  = diff[b][PW] ? diff[b] + (PW+1)'(SPAN) : diff[b];
            full[b]  = (fill[b] == (PW+1)'(QUEUE_DEPTH));
            ready[b] = (wp_reg[b] != rp_reg[b]);
        end
    end

    always_comb
    begin
        if (ready[0])
        begin
            pop_buf = 2'd0;
        end
        else if (ready[1])
        begin
            pop_buf = 2'd1;
        end
        else if (ready[2])
        begin
            pop_buf = 2'd2;
        end
        else
        begin
            pop_buf = 2'd3;
        end
    end

    assign push_buf = position[3:2];
    assign push_en  = cmd.push && !full[push_buf];
    assign wr_addr  = {push_buf, wslot[push_buf]};
    assign rd_addr  = {pop_buf, rslot[pop_buf]};

    assign tick_ext = {{(WAIT_W - TICK_W){1'b0}}, tick_period_reg};
    assign wait_dec = (wait_reg > tick_ext) ? wait_reg - tick_ext : '0;

    assign target_pos = target_reg[11:8];
    assign addr_byte  = LCD_SET_ADDR | (target_pos[3] ? LCD_LINE2 : 8'h00)
                      | {5'b0, target_pos[2:0]};
    assign out_byte   = cmd.emit_instr ? addr_byte :
                        (cmd.emit_data ? target_reg[7:0] : 8'h00);

    assign sts.out_free  = !out_valid_reg || out_tready;
    assign sts.wait_zero = (wait_dec == '0);
    assign sts.any_ready = |ready;

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = {4'b0, out_data_reg};

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem[wr_addr] <= {position, char_code};
        end
        if (cmd.pop)
        begin
            target_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {cmd.push && full[push_buf], push_en, out_byte,
                             cmd.emit_data, cmd.emit_instr || cmd.emit_data};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BUFS; b++)
            begin
                wp_reg[b] <= '0;
                rp_reg[b] <= '0;
            end
            wait_reg        <= '0;
            tick_period_reg <= TICK_PERIOD_RST;
            instr_wait_reg  <= INSTR_WAIT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (push_en)
            begin
                wp_reg[push_buf] <= wbump[push_buf];
            end
            if (cmd.pop)
            begin
                rp_reg[pop_buf] <= rbump[pop_buf];
            end
            if (cmd.load_instr)
            begin
                wait_reg <= instr_wait_reg;
            end
            else if (cmd.load_period)
            begin
                wait_reg <= tick_ext;
            end
            else if (cmd.wait_sub)
            begin
                wait_reg <= wait_dec;
            end
            if (cfg_we && cfg_index == REG_TICK_PERIOD)
            begin
                tick_period_reg <= cfg_data[TICK_W-1:0];
            end
            if (cfg_we && cfg_index == REG_INSTR_WAIT)
            begin
                instr_wait_reg <= cfg_data;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `CLCD_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid_reg,
        "result register not valid after a load")
    `CLCD_ASSERT_NEXT(a_full_flags_overflow, cmd.load_out && cmd.push && full[push_buf],
        out_data_reg[11] && !out_data_reg[10], "push into a full buffer not flagged")
    `CLCD_ASSERT(a_pop_not_empty, !cmd.pop || (|ready),
        "pop requested with every buffer empty")

endmodule
